// ----- src/omp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package omp_pkg;

   // Operand and accumulator formats
   localparam int LANES = 8;
   localparam int ACC_W = 48;
   localparam int A_W   = 16;
   localparam int B_W   = 16;
   localparam int P_W   = A_W + B_W;
   localparam int COL_W = 3;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
   localparam logic signed [A_W-1:0]   A_MAX   = {1'b0, {(A_W-1){1'b1}}};
   localparam logic signed [A_W-1:0]   A_MIN   = {1'b1, {(A_W-1){1'b0}}};

   // Request codes; code 3 is unused and does nothing
   typedef enum logic [1:0] {
      REQ_LOAD = 2'd0,
      REQ_MAC  = 2'd1,
      REQ_READ = 2'd2
   } req_code_type;

   // Controls for the operand register of a row (accept cycle)
   typedef struct packed {
      logic load_en;
      logic use_product;
   } op_ctrl_type;

   // Controls for the accumulate stage of a row
   typedef struct packed {
      logic do_write;
      logic is_mac;
      logic fwd_hit;
      logic col_valid;
   } row_ctrl_type;

   // Clamp a 48-bit lane to a Q1.15 operand
   function automatic logic signed [A_W-1:0] sat_a(input logic signed [ACC_W-1:0] v);
      logic fits;
      fits = (v[ACC_W-1:A_W-1] == {(ACC_W-A_W+1){1'b0}}) ||
             (v[ACC_W-1:A_W-1] == {(ACC_W-A_W+1){1'b1}});
      if (fits) begin
         return v[A_W-1:0];
      end else if (v[ACC_W-1]) begin
         return A_MIN;
      end else begin
         return A_MAX;
      end
   endfunction

endpackage

`default_nettype wire

// ----- src/omp_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module omp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port (read-first)
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- src/omp_row.sv -----
`timescale 1ns / 1ps
`default_nettype none

module omp_row #(
   parameter int COLS   = 8,
   parameter int COL_AW = 3
) (
   input  wire logic                               clock,
   input  wire omp_pkg::op_ctrl_type               op_ctrl,
   input  wire logic signed [omp_pkg::ACC_W-1:0]   lane,
   input  wire logic signed [omp_pkg::B_W-1:0]     b_value,
   input  wire logic [COL_AW-1:0]                  rd_addr,
   input  wire omp_pkg::row_ctrl_type              row_ctrl,
   input  wire logic [COL_AW-1:0]                  wr_addr,
   output logic signed [omp_pkg::ACC_W-1:0]        acc_value,
   output logic                                    sat_hit
);

   logic signed [omp_pkg::A_W-1:0]   a_op;
   logic signed [omp_pkg::P_W-1:0]   product;
   logic signed [omp_pkg::ACC_W-1:0] op_in;
   logic signed [omp_pkg::ACC_W-1:0] op_ff;
   logic signed [omp_pkg::ACC_W-1:0] fwd_in;
   logic signed [omp_pkg::ACC_W-1:0] fwd_ff;
   logic [omp_pkg::ACC_W-1:0]        ram_q;
   logic signed [omp_pkg::ACC_W-1:0] old_value;
   logic signed [omp_pkg::ACC_W:0]   sum_wide;
   logic signed [omp_pkg::ACC_W-1:0] new_value;

   // Accept cycle: product of clamped A and B, or the load value
   assign a_op    = omp_pkg::sat_a(lane);
   assign product = a_op * b_value;
   assign op_in   = op_ctrl.use_product
                  ? {{(omp_pkg::ACC_W-omp_pkg::P_W){product[omp_pkg::P_W-1]}}, product}
                  : lane;

   always_ff @(posedge clock) begin
      if (op_ctrl.load_en) begin
         op_ff <= op_in;
      end
   end

   // Accumulator column storage for this row
   omp_ram #(
      .WIDTH (omp_pkg::ACC_W),
      .DEPTH (COLS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (row_ctrl.do_write),
      .wr_addr (wr_addr),
      .wr_data (new_value),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   // Current value: last-cycle write bypass, else storage, else reset value
   always_comb begin
      if (row_ctrl.fwd_hit) begin
         old_value = fwd_ff;
      end else if (row_ctrl.col_valid) begin
         old_value = ram_q;
      end else begin
         old_value = '0;
      end
   end

   // Saturating 48-bit accumulate
   assign sum_wide = {old_value[omp_pkg::ACC_W-1], old_value} + {op_ff[omp_pkg::ACC_W-1], op_ff};

   always_comb begin
      sat_hit   = 1'b0;
      new_value = op_ff;
      if (row_ctrl.is_mac) begin
         if (sum_wide[omp_pkg::ACC_W] != sum_wide[omp_pkg::ACC_W-1]) begin
            sat_hit   = 1'b1;
            new_value = sum_wide[omp_pkg::ACC_W] ? omp_pkg::ACC_MIN : omp_pkg::ACC_MAX;
         end else begin
            new_value = sum_wide[omp_pkg::ACC_W-1:0];
         end
      end
   end

   // Hold the last written value for the bypass
   assign fwd_in = new_value;

   always_ff @(posedge clock) begin
      if (row_ctrl.do_write) begin
         fwd_ff <= fwd_in;
      end
   end

   assign acc_value = old_value;

endmodule

`default_nettype wire

// ----- src/outer_product_mac_8x8_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Reads: a read passes the accumulate stage register and then the result
//   register before it is strobed on rsp_valid. Load and update: no result.
// Throughput: one request per cycle; busy never asserts, the receiver cannot
//   stall, and a one-entry bypass covers back-to-back hits on one column.
// Reset (synchronous): clears pipeline valids, column valid flags and all
//   saturation marks; unwritten columns read as zero.
module outer_product_mac_8x8_top #(
   parameter int ROWS = 8,
   parameter int COLS = 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   output logic                                    busy,
   input  wire logic [1:0]                         req_type,
   input  wire logic [omp_pkg::COL_W-1:0]          req_column,
   input  wire logic signed [omp_pkg::ACC_W-1:0]   req_lane_0,
   input  wire logic signed [omp_pkg::ACC_W-1:0]   req_lane_1,
   input  wire logic signed [omp_pkg::ACC_W-1:0]   req_lane_2,
   input  wire logic signed [omp_pkg::ACC_W-1:0]   req_lane_3,
   input  wire logic signed [omp_pkg::ACC_W-1:0]   req_lane_4,
   input  wire logic signed [omp_pkg::ACC_W-1:0]   req_lane_5,
   input  wire logic signed [omp_pkg::ACC_W-1:0]   req_lane_6,
   input  wire logic signed [omp_pkg::ACC_W-1:0]   req_lane_7,
   input  wire logic signed [omp_pkg::B_W-1:0]     req_b_value,
   output logic                                    rsp_valid,
   output logic [omp_pkg::COL_W-1:0]               rsp_out_column,
   output logic signed [omp_pkg::ACC_W-1:0]        rsp_out_0,
   output logic signed [omp_pkg::ACC_W-1:0]        rsp_out_1,
   output logic signed [omp_pkg::ACC_W-1:0]        rsp_out_2,
   output logic signed [omp_pkg::ACC_W-1:0]        rsp_out_3,
   output logic signed [omp_pkg::ACC_W-1:0]        rsp_out_4,
   output logic signed [omp_pkg::ACC_W-1:0]        rsp_out_5,
   output logic signed [omp_pkg::ACC_W-1:0]        rsp_out_6,
   output logic signed [omp_pkg::ACC_W-1:0]        rsp_out_7,
   output logic                                    rsp_overflowed
);

   localparam int USED_ROWS = (ROWS < omp_pkg::LANES) ? ROWS : omp_pkg::LANES;
   localparam int COL_AW    = (COLS > 1) ? $clog2(COLS) : 1;

   logic                              accept;
   logic                              req_in_range;
   logic [COL_AW-1:0]                 rd_addr;
   logic signed [omp_pkg::ACC_W-1:0]  lanes [omp_pkg::LANES];
   omp_pkg::op_ctrl_type              op_ctrl;
   omp_pkg::row_ctrl_type             row_ctrl;

   // Accumulate stage registers
   logic                              s1_valid_ff;
   omp_pkg::req_code_type             s1_type_ff;
   logic [omp_pkg::COL_W-1:0]         s1_col_ff;
   logic [COL_AW-1:0]                 s1_addr_ff;
   logic                              s1_in_range_ff;
   logic                              s1_colvalid_ff;
   logic                              s1_is_load;
   logic                              s1_is_mac;
   logic                              s1_is_read;
   logic                              s1_write;

   // Bypass tracking of the previous cycle's write
   logic                              wr_done_ff;
   logic [COL_AW-1:0]                 wr_col_ff;

   // Column state
   logic [COLS-1:0]                   col_valid_ff;
   logic [USED_ROWS-1:0]              marks_ff [COLS];
   logic [USED_ROWS-1:0]              sat_vec;

   logic signed [omp_pkg::ACC_W-1:0]  row_value [omp_pkg::LANES];

   // Result register
   logic                              rsp_valid_ff;
   logic [omp_pkg::COL_W-1:0]         rsp_column_ff;
   logic signed [omp_pkg::ACC_W-1:0]  rsp_lane_ff [omp_pkg::LANES];
   logic                              rsp_overflowed_ff;

   // Every request is taken at once
   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign req_in_range = (32'(req_column) < COLS);
   assign rd_addr      = COL_AW'(req_column);

   assign lanes[0] = req_lane_0;
   assign lanes[1] = req_lane_1;
   assign lanes[2] = req_lane_2;
   assign lanes[3] = req_lane_3;
   assign lanes[4] = req_lane_4;
   assign lanes[5] = req_lane_5;
   assign lanes[6] = req_lane_6;
   assign lanes[7] = req_lane_7;

   assign op_ctrl.load_en     = accept;
   assign op_ctrl.use_product = (req_type == 2'(omp_pkg::REQ_MAC));

   // Accept into the accumulate stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_type_ff     <= omp_pkg::req_code_type'(req_type);
         s1_col_ff      <= req_column;
         s1_addr_ff     <= rd_addr;
         s1_in_range_ff <= req_in_range;
         s1_colvalid_ff <= req_in_range && col_valid_ff[rd_addr];
      end
   end

   // Decode the staged request
   always_comb begin
      s1_is_load = 1'b0;
      s1_is_mac  = 1'b0;
      s1_is_read = 1'b0;
      case (s1_type_ff)
         omp_pkg::REQ_LOAD: s1_is_load = 1'b1;
         omp_pkg::REQ_MAC:  s1_is_mac  = 1'b1;
         omp_pkg::REQ_READ: s1_is_read = 1'b1;
         default: begin
         end
      endcase
   end

   assign s1_write = s1_valid_ff && s1_in_range_ff && (s1_is_load || s1_is_mac);

   assign row_ctrl.do_write  = s1_write;
   assign row_ctrl.is_mac    = s1_is_mac;
   assign row_ctrl.fwd_hit   = wr_done_ff && (wr_col_ff == s1_addr_ff);
   assign row_ctrl.col_valid = s1_colvalid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_done_ff <= 1'b0;
      end else begin
         wr_done_ff <= s1_write;
      end
      if (s1_write) begin
         wr_col_ff <= s1_addr_ff;
      end
   end

   // Row datapaths; lanes without a row read as zero
   for (genvar r = 0; r < omp_pkg::LANES; r++) begin : g_row
      if (r < USED_ROWS) begin : g_used
         omp_row #(
            .COLS   (COLS),
            .COL_AW (COL_AW)
         ) u_row (
            .clock     (clock),
            .op_ctrl   (op_ctrl),
            .lane      (lanes[r]),
            .b_value   (req_b_value),
            .rd_addr   (rd_addr),
            .row_ctrl  (row_ctrl),
            .wr_addr   (s1_addr_ff),
            .acc_value (row_value[r]),
            .sat_hit   (sat_vec[r])
         );
      end else begin : g_empty
         assign row_value[r] = '0;
      end
   end

   // Column valid flags and sticky saturation marks
   always_ff @(posedge clock) begin
      for (int c = 0; c < COLS; c++) begin
         if (reset) begin
            col_valid_ff[c] <= 1'b0;
            marks_ff[c]     <= '0;
         end else if (s1_write && (s1_addr_ff == COL_AW'(c))) begin
            col_valid_ff[c] <= 1'b1;
            if (s1_is_load) begin
               marks_ff[c] <= '0;
            end else begin
               marks_ff[c] <= marks_ff[c] | sat_vec;
            end
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff && s1_is_read;
      end
      if (s1_valid_ff && s1_is_read) begin
         rsp_column_ff     <= s1_col_ff;
         rsp_overflowed_ff <= s1_in_range_ff && (|marks_ff[s1_addr_ff]);
         for (int r = 0; r < omp_pkg::LANES; r++) begin
            rsp_lane_ff[r] <= s1_in_range_ff ? row_value[r] : '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_column = rsp_column_ff;
   assign rsp_out_0      = rsp_lane_ff[0];
   assign rsp_out_1      = rsp_lane_ff[1];
   assign rsp_out_2      = rsp_lane_ff[2];
   assign rsp_out_3      = rsp_lane_ff[3];
   assign rsp_out_4      = rsp_lane_ff[4];
   assign rsp_out_5      = rsp_lane_ff[5];
   assign rsp_out_6      = rsp_lane_ff[6];
   assign rsp_out_7      = rsp_lane_ff[7];
   assign rsp_overflowed = rsp_overflowed_ff;

   // A result strobe only follows an accepted read, through the accumulate stage and result register
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(accept, 2) && ($past(req_type, 2) == 2'(omp_pkg::REQ_READ))))
      else $error("result strobe without a read transfer");

   // A written column is marked valid on the next cycle
   a_col_valid_set: assert property (@(posedge clock) disable iff (reset)
      s1_write |=> col_valid_ff[$past(s1_addr_ff)])
      else $error("column valid flag not set after write");

   // Out-of-range reads return zero data (lanes 0 and 7 checked) and no overflow
   a_oor_read_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_is_read && !s1_in_range_ff) |=>
         (!rsp_overflowed && (rsp_out_0 == '0) && (rsp_out_7 == '0)))
      else $error("out-of-range read returned nonzero data");

   // A load clears the saturation marks of its column
   a_load_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_write && s1_is_load) |=> (marks_ff[$past(s1_addr_ff)] == '0))
      else $error("load left saturation marks set");

endmodule

`default_nettype wire
